// File: design/ckq_pkg.sv
// ----------------------------------------------------------------------------
// ckq_pkg
// Shared types, widths and request codes of the prescaler and scancode queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ckq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CYC_W   = 10;
	localparam int FAST_W  = 5;
	localparam int SLOW_W  = 12;
	localparam int SUM_W   = CYC_W + 1;
	localparam int TICK_W  = 9;
	localparam int BYTE_W  = 8;

	localparam int PORTB_SPK_BIT  = 0;
	localparam int PORTB_RAMS_BIT = 2;
	localparam int PORTB_KBD_BIT  = 7;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [2:0] {
		REQ_ADVANCE = 3'd0,
		REQ_PUSH    = 3'd1,
		REQ_READ_A  = 3'd2,
		REQ_READ_C  = 3'd3,
		REQ_WRITE_B = 3'd4
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SWITCHES = 2'd0,
		CFG_RAM_LOW  = 2'd1,
		CFG_RAM_HIGH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              fast;
		logic [TICK_W-1:0] ticks;
		logic              slow;
	} tick_t;

	typedef struct packed {
		logic push;
		logic slow_tick;
	} q_ctl_t;

	typedef struct packed {
		logic irq;
		logic dropped;
	} q_stat_t;

endpackage

`default_nettype wire

// File: design/ckq_ram.sv
// ----------------------------------------------------------------------------
// ckq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ckq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/ckq_prescale.sv
// ----------------------------------------------------------------------------
// ckq_prescale
// Prescaler with a 5-bit fast accumulator feeding a 12-bit slow divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ckq_prescale (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic [ckq_pkg::CYC_W-1:0] cycle_count,
	output ckq_pkg::tick_t                 tick
);

	import ckq_pkg::*;

	logic [FAST_W-1:0] fast_q;
	logic [SLOW_W-1:0] slow_q;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  whole;
	logic [SLOW_W:0]   slow_sum;
	logic              fired;

	assign sum      = SUM_W'(fast_q) + SUM_W'(cycle_count);
	assign fired    = |sum[SUM_W-1:FAST_W];
	assign whole    = {sum[SUM_W-1:FAST_W], {FAST_W{1'b0}}};
	assign slow_sum = {1'b0, slow_q} + (SLOW_W+1)'(whole);

	assign tick.fast  = fired;
	assign tick.ticks = fired ? TICK_W'({sum[SUM_W-1:FAST_W], 3'b000}) : '0;
	assign tick.slow  = fired & slow_sum[SLOW_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= '0;
			slow_q <= '0;
		end else if (advance) begin
			fast_q <= sum[FAST_W-1:0];
			if (fired) begin
				slow_q <= slow_sum[SLOW_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ckq_queue.sv
// ----------------------------------------------------------------------------
// ckq_queue
// Scancode queue: store, read and write pointers, and the scancode latch.
// ----------------------------------------------------------------------------
`default_nettype none

module ckq_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ckq_pkg::q_ctl_t            ctl,
	input  wire logic [ckq_pkg::BYTE_W-1:0] push_data,
	output ckq_pkg::q_stat_t                stat,
	output logic      [ckq_pkg::BYTE_W-1:0] latch
);

	import ckq_pkg::*;

	logic [QCNT_W-1:0] rd_q;
	logic [QCNT_W-1:0] wr_q;
	logic [QCNT_W-1:0] rd_next;
	logic              latched_q;
	logic              full;
	logic              pop;
	logic              wr_en;
	logic [BYTE_W-1:0] ram_rdata;

	assign full    = wr_q >= QCNT_W'(QUEUE_DEPTH);
	assign pop     = ctl.slow_tick & (rd_q < wr_q);
	assign wr_en   = ctl.push & ~full;
	assign rd_next = rd_q + QCNT_W'(1);

	assign stat.irq     = pop;
	assign stat.dropped = ctl.push & full;

	ckq_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_q[QIDX_W-1:0]),
		.wdata(push_data),
		.re   (pop),
		.raddr(rd_q[QIDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign latch = latched_q ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= '0;
			wr_q      <= '0;
			latched_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + QCNT_W'(1);
			end
			if (pop) begin
				latched_q <= 1'b1;
				if (rd_next == wr_q) begin
					rd_q <= '0;
					wr_q <= '0;
				end else begin
					rd_q <= rd_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/clock_prescaler_and_scancode_queue_top.sv
// ----------------------------------------------------------------------------
// clock_prescaler_and_scancode_queue_top
// Board glue: CPU-cycle prescaler, slow divider, scancode queue, PPI ports.
//
// Channel   Dir  Handshake             Contents
// s_axis    in   tvalid/tready         tuser: req_type; tdata: cycle_count, data_byte
// m_axis    out  tvalid/tready         tdata: read_data and status flags
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data (switch registers)
//
// One word per cycle unless m_axis stalls; words pass the input and result registers.
// The input register and the result register are the only stages; a stalled
// m_axis holds the result and lets one more word wait in the input register.
// Reset clears pointers, dividers, port B and restores the switch defaults.
// cfg_ready is always high; the scancode store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_prescaler_and_scancode_queue_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [23:0]                   s_axis_tdata,  // cycle_count, data_byte
	input  wire logic [2:0]                    s_axis_tuser,  // req_type
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// read_data, fast_strobe, timer_ticks, slow_strobe, keyboard_irq,
	// speaker_gate, key_dropped
	output logic      [23:0]                   m_axis_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ckq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	import ckq_pkg::*;

	logic              s1_valid_q;
	logic [2:0]        req_s1;
	logic [CYC_W-1:0]  cycles_s1;
	logic [BYTE_W-1:0] data_s1;

	logic              out_valid_q;
	logic [21:0]       out_q;

	logic [BYTE_W-1:0] switches_q;
	logic [3:0]        ram_low_q;
	logic              ram_high_q;
	logic [BYTE_W-1:0] port_b_q;

	logic              commit;
	logic              is_adv;
	tick_t             tick;
	q_ctl_t            qctl;
	q_stat_t           qstat;
	logic [BYTE_W-1:0] latch;
	logic [BYTE_W-1:0] rd_data;
	logic              gate;
	logic [21:0]       result;

	assign commit        = s1_valid_q & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~s1_valid_q | commit;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tvalid & s_axis_tready) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid & s_axis_tready) begin
			req_s1    <= s_axis_tuser;
			cycles_s1 <= s_axis_tdata[9:0];
			data_s1   <= s_axis_tdata[17:10];
		end
	end

	assign is_adv = req_s1 == REQ_ADVANCE;

	ckq_prescale u_prescale (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (commit & is_adv),
		.cycle_count(cycles_s1),
		.tick       (tick)
	);

	assign qctl.push      = commit & (req_s1 == REQ_PUSH);
	assign qctl.slow_tick = commit & is_adv & tick.slow;

	ckq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.push_data(data_s1),
		.stat     (qstat),
		.latch    (latch)
	);

	always_comb begin
		rd_data = '0;
		gate    = port_b_q[PORTB_SPK_BIT];
		unique case (req_s1)
			REQ_READ_A: begin
				rd_data = port_b_q[PORTB_KBD_BIT] ? switches_q : latch;
			end
			REQ_READ_C: begin
				rd_data = port_b_q[PORTB_RAMS_BIT] ? BYTE_W'(ram_high_q)
				                                   : BYTE_W'(ram_low_q);
			end
			REQ_WRITE_B: begin
				gate = data_s1[PORTB_SPK_BIT];
			end
			default: begin
				rd_data = '0;
			end
		endcase
	end

	assign result = {
		(req_s1 == REQ_PUSH) & qstat.dropped,
		gate,
		is_adv & qstat.irq,
		is_adv & tick.slow,
		is_adv ? tick.ticks : TICK_W'(0),
		is_adv & tick.fast,
		rd_data
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_b_q   <= '0;
			switches_q <= 8'd60;
			ram_low_q  <= '0;
			ram_high_q <= 1'b0;
		end else begin
			if (commit & (req_s1 == REQ_WRITE_B)) begin
				port_b_q <= data_s1;
			end
			if (cfg_valid & cfg_ready) begin
				unique case (cfg_index)
					CFG_SWITCHES: switches_q <= cfg_data;
					CFG_RAM_LOW:  ram_low_q  <= cfg_data[3:0];
					CFG_RAM_HIGH: ram_high_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire
